### rtl/quaternion_to_rotation_matrix_core_assert.svh
// Assertion macros used by the quaternion to rotation matrix core.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qrm_pkg.sv
// Types, constants and rounding helper for the quaternion to rotation matrix pipeline.
`default_nettype none
package qrm_pkg;

    // Q1.15 sample, exact Q2.30 product, and product sum with one guard bit
    typedef logic signed [15:0] t_q15;
    typedef logic signed [31:0] t_prod;
    typedef logic signed [32:0] t_sum;
    typedef logic signed [33:0] t_bias;
    typedef logic signed [19:0] t_rnd;

    localparam int FRAC_DROP = 14;
    localparam t_sum ONE_Q29 = t_sum'(64'sd1 <<< 29);
    localparam t_bias ROUND_HALF = t_bias'(64'sd1 <<< (FRAC_DROP - 1));
    localparam t_rnd Q15_MAX = t_rnd'(32767);
    localparam t_rnd Q15_MIN = t_rnd'(-32768);

    // products needed by the matrix (ww is not used)
    typedef struct packed {
        t_prod xx;
        t_prod xy;
        t_prod xz;
        t_prod xw;
        t_prod yy;
        t_prod yz;
        t_prod yw;
        t_prod zz;
        t_prod zw;
    } t_prods;

    // matrix entries before rounding, units of 2^-29, row-major
    typedef struct packed {
        t_sum m00;
        t_sum m01;
        t_sum m02;
        t_sum m10;
        t_sum m11;
        t_sum m12;
        t_sum m20;
        t_sum m21;
        t_sum m22;
    } t_sums;

    // round half up to Q1.15, then saturate
    function automatic t_q15 round_sat(input t_sum num);
        t_bias biased;
        t_rnd  shifted;
        t_q15  res;
        biased  = t_bias'(num) + ROUND_HALF;
        shifted = t_rnd'(biased >>> FRAC_DROP);
        if (shifted > Q15_MAX) begin
            res = t_q15'(Q15_MAX);
        end else if (shifted < Q15_MIN) begin
            res = t_q15'(Q15_MIN);
        end else begin
            res = shifted[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/qrm_mult.sv
// Stage 1: the nine pairwise products of the quaternion components.
`default_nettype none
module qrm_mult (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire qrm_pkg::t_q15   i_quat_x,
    input  wire qrm_pkg::t_q15   i_quat_y,
    input  wire qrm_pkg::t_q15   i_quat_z,
    input  wire qrm_pkg::t_q15   i_quat_w,
    output logic                 o_valid,
    output qrm_pkg::t_prods      o_prods
);
    import qrm_pkg::*;

    logic   r_valid;
    t_prods r_prods;
    t_prods n_prods;

    // exact signed 16x16 products
    always_comb begin
        n_prods.xx = t_prod'(i_quat_x) * t_prod'(i_quat_x);
        n_prods.xy = t_prod'(i_quat_x) * t_prod'(i_quat_y);
        n_prods.xz = t_prod'(i_quat_x) * t_prod'(i_quat_z);
        n_prods.xw = t_prod'(i_quat_x) * t_prod'(i_quat_w);
        n_prods.yy = t_prod'(i_quat_y) * t_prod'(i_quat_y);
        n_prods.yz = t_prod'(i_quat_y) * t_prod'(i_quat_z);
        n_prods.yw = t_prod'(i_quat_y) * t_prod'(i_quat_w);
        n_prods.zz = t_prod'(i_quat_z) * t_prod'(i_quat_z);
        n_prods.zw = t_prod'(i_quat_z) * t_prod'(i_quat_w);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en && i_valid) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule
`default_nettype wire

### rtl/qrm_comb.sv
// Stage 2: sums and differences of products forming the nine matrix entries.
`default_nettype none
module qrm_comb (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire qrm_pkg::t_prods i_prods,
    output logic                 o_valid,
    output qrm_pkg::t_sums       o_sums
);
    import qrm_pkg::*;

    logic  r_valid;
    t_sums r_sums;
    t_sums n_sums;

    // 2*product in Q2.30 is the product in units of 2^-29; 33 bits never overflow
    always_comb begin
        n_sums.m00 = ONE_Q29 - (t_sum'(i_prods.yy) + t_sum'(i_prods.zz));
        n_sums.m01 = t_sum'(i_prods.xy) - t_sum'(i_prods.zw);
        n_sums.m02 = t_sum'(i_prods.xz) + t_sum'(i_prods.yw);
        n_sums.m10 = t_sum'(i_prods.xy) + t_sum'(i_prods.zw);
        n_sums.m11 = ONE_Q29 - (t_sum'(i_prods.xx) + t_sum'(i_prods.zz));
        n_sums.m12 = t_sum'(i_prods.yz) - t_sum'(i_prods.xw);
        n_sums.m20 = t_sum'(i_prods.xz) - t_sum'(i_prods.yw);
        n_sums.m21 = t_sum'(i_prods.yz) + t_sum'(i_prods.xw);
        n_sums.m22 = ONE_Q29 - (t_sum'(i_prods.xx) + t_sum'(i_prods.yy));
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en && i_valid) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule
`default_nettype wire

### rtl/qrm_sat.sv
// Stage 3: rounding to Q1.15 with saturation into the output register.
`default_nettype none
module qrm_sat (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire qrm_pkg::t_sums  i_sums,
    output logic                 o_valid,
    output qrm_pkg::t_q15        o_r00,
    output qrm_pkg::t_q15        o_r01,
    output qrm_pkg::t_q15        o_r02,
    output qrm_pkg::t_q15        o_r10,
    output qrm_pkg::t_q15        o_r11,
    output qrm_pkg::t_q15        o_r12,
    output qrm_pkg::t_q15        o_r20,
    output qrm_pkg::t_q15        o_r21,
    output qrm_pkg::t_q15        o_r22
);
    import qrm_pkg::*;

    logic r_valid;
    t_q15 r_r00, r_r01, r_r02, r_r10, r_r11, r_r12, r_r20, r_r21, r_r22;

    // output register, loads rounded entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en && i_valid) begin
            r_r00 <= round_sat(i_sums.m00);
            r_r01 <= round_sat(i_sums.m01);
            r_r02 <= round_sat(i_sums.m02);
            r_r10 <= round_sat(i_sums.m10);
            r_r11 <= round_sat(i_sums.m11);
            r_r12 <= round_sat(i_sums.m12);
            r_r20 <= round_sat(i_sums.m20);
            r_r21 <= round_sat(i_sums.m21);
            r_r22 <= round_sat(i_sums.m22);
        end
    end

    assign o_valid = r_valid;
    assign o_r00   = r_r00;
    assign o_r01   = r_r01;
    assign o_r02   = r_r02;
    assign o_r10   = r_r10;
    assign o_r11   = r_r11;
    assign o_r12   = r_r12;
    assign o_r20   = r_r20;
    assign o_r21   = r_r21;
    assign o_r22   = r_r22;

endmodule
`default_nettype wire

### rtl/quaternion_to_rotation_matrix_core.sv
// Quaternion (Q1.15) to 3x3 rotation matrix (Q1.15, saturated), three-stage pipeline.
//
// Input channel: i_valid / o_stall with i_quat_x, i_quat_y, i_quat_z, i_quat_w.
// Output channel: o_valid / i_stall with o_r00 .. o_r22 in row-major order.
// An item moves at a clock edge where valid is high and stall is low.
// An accepted item passes the mult, comb and sat stage registers in that order;
// o_valid is high once it sits in the sat register, and it can leave from there.
// Throughput: one item per cycle while the output is not stalled; the stages do
// 16x16 multiplies, up to two 33-bit adds per entry, and round-and-clamp in turn.
// Each stage advances when it is empty or the stage after it advances, so
// empty slots close up while the output is stalled. o_stall rises only
// when all three stages hold items and the receiver stalls.
// A stalled output holds its values; nothing is dropped or repeated.
// Synchronous reset (i_rst_n low) empties the pipeline; items in flight are
// discarded and o_valid is low after reset.
// The identity quaternion yields 32767 on the diagonal (+1.0 saturates).
`default_nettype none
module quaternion_to_rotation_matrix_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire qrm_pkg::t_q15   i_quat_x,
    input  wire qrm_pkg::t_q15   i_quat_y,
    input  wire qrm_pkg::t_q15   i_quat_z,
    input  wire qrm_pkg::t_q15   i_quat_w,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output qrm_pkg::t_q15        o_r00,
    output qrm_pkg::t_q15        o_r01,
    output qrm_pkg::t_q15        o_r02,
    output qrm_pkg::t_q15        o_r10,
    output qrm_pkg::t_q15        o_r11,
    output qrm_pkg::t_q15        o_r12,
    output qrm_pkg::t_q15        o_r20,
    output qrm_pkg::t_q15        o_r21,
    output qrm_pkg::t_q15        o_r22
);
    import qrm_pkg::*;

    `include "quaternion_to_rotation_matrix_core_assert.svh"

    logic   mult_valid;
    logic   comb_valid;
    logic   sat_valid;
    logic   sat_en;
    logic   comb_en;
    logic   mult_en;
    t_prods prods;
    t_sums  sums;

    // per-stage advance: a stage loads when empty or when its successor moves
    assign sat_en  = !sat_valid || !i_stall;
    assign comb_en = !comb_valid || sat_en;
    assign mult_en = !mult_valid || comb_en;
    assign o_stall = !mult_en;
    assign o_valid = sat_valid;

    qrm_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (mult_en),
        .i_valid  (i_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .o_valid  (mult_valid),
        .o_prods  (prods)
    );

    qrm_comb u_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (comb_en),
        .i_valid (mult_valid),
        .i_prods (prods),
        .o_valid (comb_valid),
        .o_sums  (sums)
    );

    qrm_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (sat_en),
        .i_valid (comb_valid),
        .i_sums  (sums),
        .o_valid (sat_valid),
        .o_r00   (o_r00),
        .o_r01   (o_r01),
        .o_r02   (o_r02),
        .o_r10   (o_r10),
        .o_r11   (o_r11),
        .o_r12   (o_r12),
        .o_r20   (o_r20),
        .o_r21   (o_r21),
        .o_r22   (o_r22)
    );

    // back-pressure only when the pipeline is full
    `QRM_ASSERT_NOW(a_stall_full, o_stall,
        mult_valid && comb_valid && sat_valid && i_stall, "input stalled with a free stage")
    // an accepted item lands in the first stage
    `QRM_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, mult_valid,
        "accepted item not captured")
    // an item in stage 2 behind a stalled output is kept
    `QRM_ASSERT_NEXT(a_hold_mid, comb_valid && sat_valid && i_stall, comb_valid,
        "item lost in stage 2 under stall")
    // an item in stage 1 stays there while stage 2 cannot take it
    `QRM_ASSERT_NEXT(a_hold_first, mult_valid && !comb_en, mult_valid,
        "item lost in stage 1 under stall")

endmodule
`default_nettype wire

### dv/quaternion_to_rotation_matrix_core_tb.sv
// Self-checking testbench for quaternion_to_rotation_matrix_core with a scoreboard class.
module quaternion_to_rotation_matrix_core_tb;
    import qrm_pkg::t_q15;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int NUM_RANDOM   = 1350;
    localparam int NUM_DIRECTED = 19;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // nine matrix entries, r00 in slice 0 through r22 in slice 8
    typedef logic [8:0][15:0] t_mat;

    // Expected-matrix store with its own fixed-point rotation predictor
    class matrix_scoreboard;
        t_mat        pending_mats[$];
        int unsigned quats_seen;
        int unsigned mats_checked;
        int unsigned full_scale;
        int unsigned errors;

        // round half up from units of 2^-29 to Q1.15, then clamp
        function t_q15 q15_round_sat(longint num);
            longint r;
            r = (num + 64'sd8192) >>> 14;
            if (r > 32767) begin
                r = 32767;
            end else if (r < -32768) begin
                r = -32768;
            end
            return t_q15'(r);
        endfunction

        function t_mat rotation_of(t_q15 qx, t_q15 qy, t_q15 qz, t_q15 qw);
            longint x, y, z, w;
            longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
            longint one;
            t_mat   m;
            x = qx;
            y = qy;
            z = qz;
            w = qw;
            one = 64'sd1 <<< 29;
            // Q2.30 products; doubling them lands in units of 2^-29
            xx = x * x; xy = x * y; xz = x * z; xw = x * w;
            yy = y * y; yz = y * z; yw = y * w;
            zz = z * z; zw = z * w;
            m[0] = q15_round_sat(one - (yy + zz));
            m[1] = q15_round_sat(xy - zw);
            m[2] = q15_round_sat(xz + yw);
            m[3] = q15_round_sat(xy + zw);
            m[4] = q15_round_sat(one - (xx + zz));
            m[5] = q15_round_sat(yz - xw);
            m[6] = q15_round_sat(xz - yw);
            m[7] = q15_round_sat(yz + xw);
            m[8] = q15_round_sat(one - (xx + yy));
            return m;
        endfunction

        function void note_quat(t_q15 qx, t_q15 qy, t_q15 qz, t_q15 qw);
            t_mat m;
            m = rotation_of(qx, qy, qz, qw);
            pending_mats.push_back(m);
            quats_seen++;
            for (int i = 0; i < 9; i++) begin
                if (m[i] == 16'h7FFF || m[i] == 16'h8000) begin
                    full_scale++;
                end
            end
        endfunction

        function void check_matrix(t_mat got);
            t_mat exp_m;
            if (pending_mats.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: matrix out with no quaternion pending");
                end
                return;
            end
            exp_m = pending_mats.pop_front();
            mats_checked++;
            // field-by-field compare
            for (int i = 0; i < 9; i++) begin
                if (got[i] !== exp_m[i]) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR: matrix %0d r%0d%0d expected %0d got %0d",
                                 mats_checked, i / 3, i % 3,
                                 $signed(exp_m[i]), $signed(got[i]));
                    end
                end
            end
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_q15  i_quat_x;
    t_q15  i_quat_y;
    t_q15  i_quat_z;
    t_q15  i_quat_w;
    logic  o_valid;
    logic  i_stall;
    t_q15  o_r00, o_r01, o_r02;
    t_q15  o_r10, o_r11, o_r12;
    t_q15  o_r20, o_r21, o_r22;

    matrix_scoreboard sb;
    int unsigned      cycle_count;
    int unsigned      stall_mode;
    int unsigned      stall_left;
    int unsigned      stall_phase;

    // x, y, z, w from the top halfword down
    logic [63:0] directed_quats [0:NUM_DIRECTED-1] = '{
        64'h0000_0000_0000_0000,  // zero quaternion
        64'h0000_0000_0000_7FFF,  // identity, diagonal saturates
        64'h0000_0000_0000_8000,  // w = -1.0
        64'h7FFF_0000_0000_0000,
        64'h0000_7FFF_0000_0000,
        64'h0000_0000_7FFF_0000,
        64'h8000_0000_0000_0000,
        64'h8000_8000_8000_8000,  // all -1.0, far from unit length
        64'h7FFF_7FFF_7FFF_7FFF,
        64'h8000_7FFF_8000_7FFF,
        64'h7FFF_8000_7FFF_8000,
        64'h5A82_0000_0000_5A82,  // quarter turn about x
        64'h4000_4000_4000_4000,
        64'hC000_4000_C000_4000,
        64'h0040_0080_0000_0000,  // off-diagonal exactly halfway, positive
        64'hFFC0_0080_0000_0000,  // halfway, negative: rounds up to zero
        64'h0001_0001_0001_0001,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_5A82_A57E
    };

    quaternion_to_rotation_matrix_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_r00    (o_r00),
        .o_r01    (o_r01),
        .o_r02    (o_r02),
        .o_r10    (o_r10),
        .o_r11    (o_r11),
        .o_r12    (o_r12),
        .o_r20    (o_r20),
        .o_r21    (o_r21),
        .o_r22    (o_r22)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_matrix({o_r22, o_r21, o_r20, o_r12, o_r11, o_r10,
                                 o_r02, o_r01, o_r00});
            end
            if (i_valid && !o_stall) begin
                sb.note_quat(i_quat_x, i_quat_y, i_quat_z, i_quat_w);
            end
        end
    end

    // Receiver stall: modes of random length, including runs with no stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left = stall_left - 1;
        end
        stall_phase = stall_phase + 1;
        case (stall_mode)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 3) == 0);
            2: i_stall = ($urandom_range(0, 3) != 0);
            default: i_stall = ((stall_phase % 5) < 2);
        endcase
    end

    function automatic t_q15 edge_value();
        case ($urandom_range(0, 6))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return 16'sh7FFF;
            3: return 16'sh0000;
            4: return 16'sh0001;
            5: return 16'shFFFF;
            default: return t_q15'($urandom);
        endcase
    endfunction

    // Mostly unit quaternions, then raw bits, edge mixes and tiny values
    task automatic make_quat(output t_q15 qx, output t_q15 qy,
                             output t_q15 qz, output t_q15 qw);
        real cx, cy, cz, cw, norm;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            cx = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
            cy = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
            cz = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
            cw = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
            norm = $sqrt(cx * cx + cy * cy + cz * cz + cw * cw);
            if (norm < 0.01) begin
                cx = 0.0; cy = 0.0; cz = 0.0; cw = 1.0; norm = 1.0;
            end
            qx = t_q15'($rtoi(cx / norm * 32767.0));
            qy = t_q15'($rtoi(cy / norm * 32767.0));
            qz = t_q15'($rtoi(cz / norm * 32767.0));
            qw = t_q15'($rtoi(cw / norm * 32767.0));
        end else if (pick < 75) begin
            qx = t_q15'($urandom);
            qy = t_q15'($urandom);
            qz = t_q15'($urandom);
            qw = t_q15'($urandom);
        end else if (pick < 90) begin
            qx = edge_value();
            qy = edge_value();
            qz = edge_value();
            qw = edge_value();
        end else begin
            qx = t_q15'($urandom_range(0, 511) - 256);
            qy = t_q15'($urandom_range(0, 511) - 256);
            qz = t_q15'($urandom_range(0, 511) - 256);
            qw = t_q15'($urandom_range(0, 511) - 256);
        end
    endtask

    // Present one item at the falling edge and hold it until taken
    task automatic send_quat(t_q15 qx, t_q15 qy, t_q15 qz, t_q15 qw);
        i_valid  = 1'b1;
        i_quat_x = qx;
        i_quat_y = qy;
        i_quat_z = qz;
        i_quat_w = qw;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // Sender gap with junk on the payload
    task automatic sender_gap(int unsigned cycles);
        i_valid = 1'b0;
        repeat (cycles) begin
            i_quat_x = t_q15'($urandom);
            i_quat_y = t_q15'($urandom);
            i_quat_z = t_q15'($urandom);
            i_quat_w = t_q15'($urandom);
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_q15        qx, qy, qz, qw;
        int unsigned sent;
        int unsigned burst;
        sb = new();
        cycle_count = 0;
        stall_mode  = 0;
        stall_left  = 0;
        stall_phase = 0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_quat_x = '0;
        i_quat_y = '0;
        i_quat_z = '0;
        i_quat_w = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed items back to back
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_quat(directed_quats[i][63:48], directed_quats[i][47:32],
                      directed_quats[i][31:16], directed_quats[i][15:0]);
        end
        sender_gap($urandom_range(0, 6));

        // Random items in bursts; some gaps between bursts are zero
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < NUM_RANDOM; b++) begin
                make_quat(qx, qy, qz, qw);
                send_quat(qx, qy, qz, qw);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                sender_gap($urandom_range(1, 8));
            end
        end
        i_valid = 1'b0;

        // Drain, then wait DRAIN_CYCLES longer for stray results
        while (sb.pending_mats.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d quaternions (%0d directed), %0d matrices compared,",
                 sb.quats_seen, NUM_DIRECTED, sb.mats_checked);
        $display("%0d full-scale entries expected, %0d field mismatches",
                 sb.full_scale, sb.errors);
        if (sb.errors == 0 && sb.pending_mats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/qrm_pkg.sv
rtl/qrm_mult.sv
rtl/qrm_comb.sv
rtl/qrm_sat.sv
rtl/quaternion_to_rotation_matrix_core.sv
dv/quaternion_to_rotation_matrix_core_tb.sv
